@@ rtl/rlfw_pkg.sv @@
`timescale 1ns / 1ps

package rlfw_pkg;

  localparam int ID_W    = 4;
  localparam int DEPTH_W = 8;
  localparam int FILL_W  = 5;
  localparam int MAX_IDS = 16;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH = 8'd255;

  typedef enum logic [0:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_NESTED    = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_DECREMENT = 3'd3,
    ST_FREED     = 3'd4,
    ST_HANDOFF   = 3'd5,
    ST_NOT_OWNER = 3'd6,
    ST_OTHER_ERR = 3'd7
  } status_t;

  // Core to wait queue: one push or one pop per transaction, plus the waiting lookup.
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
    logic [ID_W-1:0] query_id;
  } qctrl_t;

  // Wait queue to core.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic              is_waiting;
    logic [ID_W-1:0]   head_id;
    logic [FILL_W-1:0] fill;
  } qstat_t;

  typedef struct packed {
    status_t            status;
    logic               woken_valid;
    logic [ID_W-1:0]    woken_thread;
    logic [ID_W-1:0]    owner_now;
    logic               owned_now;
    logic [DEPTH_W-1:0] hold_depth;
    logic [FILL_W-1:0]  queue_length;
  } res_t;

endpackage

@@ rtl/rlfw_queue.sv @@
`timescale 1ns / 1ps

module rlfw_queue #(
  parameter int THREADS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  rlfw_pkg::qctrl_t ctrl,
  output rlfw_pkg::qstat_t stat
);
  import rlfw_pkg::*;

  // Only MAX_IDS thread ids can ever arrive, so at most that many can wait.
  localparam int QDEPTH = (THREADS < MAX_IDS) ? THREADS : MAX_IDS;
  localparam int PW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);

  logic [ID_W-1:0]   entries [QDEPTH];
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [FILL_W-1:0] fill;
  logic [QDEPTH-1:0] waiting;

  logic query_ok;

  assign query_ok = (32'(ctrl.query_id) < QDEPTH);

  always_comb begin
    stat.full       = (fill == FILL_W'(QDEPTH));
    stat.empty      = (fill == '0);
    stat.head_id    = entries[head];
    stat.fill       = fill;
    stat.is_waiting = query_ok && waiting[ctrl.query_id[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      waiting <= '0;
    end else if (fire) begin
      if (ctrl.push) begin
        tail                        <= (tail == LAST) ? '0 : tail + 1'b1;
        waiting[ctrl.push_id[PW-1:0]] <= 1'b1;
      end
      if (ctrl.pop) begin
        head                         <= (head == LAST) ? '0 : head + 1'b1;
        waiting[entries[head][PW-1:0]] <= 1'b0;
      end
      if (ctrl.push && !ctrl.pop) begin
        fill <= fill + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.push) begin
      entries[tail] <= ctrl.push_id;
    end
  end

endmodule

@@ rtl/rlfw_core.sv @@
`timescale 1ns / 1ps

module rlfw_core #(
  parameter int THREADS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          cmd,
  input  logic [rlfw_pkg::ID_W-1:0]     tid,
  input  rlfw_pkg::qstat_t              qstat,
  output rlfw_pkg::qctrl_t              qctrl,
  output rlfw_pkg::res_t                res
);
  import rlfw_pkg::*;

  logic               held;
  logic [ID_W-1:0]    owner;
  logic [DEPTH_W-1:0] count;

  logic               held_next;
  logic [ID_W-1:0]    owner_next;
  logic [DEPTH_W-1:0] count_next;
  status_t            st;
  logic               tid_ok;

  assign tid_ok = (32'(tid) < THREADS);

  always_comb begin
    held_next      = held;
    owner_next     = owner;
    count_next     = count;
    st             = ST_OTHER_ERR;
    qctrl.push     = 1'b0;
    qctrl.pop      = 1'b0;
    qctrl.push_id  = tid;
    qctrl.query_id = tid;

    if (!tid_ok) begin
      st = ST_OTHER_ERR;
    end else if (cmd == CMD_ACQUIRE) begin
      if (!held) begin
        held_next  = 1'b1;
        owner_next = tid;
        count_next = DEPTH_W'(1);
        st         = ST_GRANTED;
      end else if (owner == tid) begin
        if (count == MAX_DEPTH) begin
          st = ST_OTHER_ERR;
        end else begin
          count_next = count + 1'b1;
          st         = ST_NESTED;
        end
      end else if (qstat.is_waiting || qstat.full) begin
        st = ST_OTHER_ERR;
      end else begin
        qctrl.push = 1'b1;
        st         = ST_QUEUED;
      end
    end else begin
      if (!held || owner != tid) begin
        st = ST_NOT_OWNER;
      end else if (count > DEPTH_W'(1)) begin
        count_next = count - 1'b1;
        st         = ST_DECREMENT;
      end else if (!qstat.empty) begin
        qctrl.pop  = 1'b1;
        owner_next = qstat.head_id;
        count_next = DEPTH_W'(1);
        st         = ST_HANDOFF;
      end else begin
        held_next  = 1'b0;
        owner_next = '0;
        count_next = '0;
        st         = ST_FREED;
      end
    end

    res.status       = st;
    res.woken_valid  = (st == ST_HANDOFF);
    res.woken_thread = (st == ST_HANDOFF) ? qstat.head_id : '0;
    res.owned_now    = held_next;
    res.owner_now    = held_next ? owner_next : '0;
    res.hold_depth   = held_next ? count_next : '0;
    res.queue_length = qstat.fill + FILL_W'(qctrl.push) - FILL_W'(qctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
      count <= '0;
    end else if (fire) begin
      held  <= held_next;
      owner <= owner_next;
      count <= count_next;
    end
  end

endmodule

@@ rtl/recursive_lock_fifo_waiters.sv @@
`timescale 1ns / 1ps
// Recursive lock with FIFO wait queue.
// Throughput: one transaction per cycle while out_stall does not hold the result register;
// input register -> decision logic -> result register.
// Reset (rst, synchronous, active high): lock free, depth 0, queue empty, nobody waiting.
// Queue entries are not cleared; only slots of live waiters are ever read.
module recursive_lock_fifo_waiters #(
  parameter int THREADS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [rlfw_pkg::ID_W-1:0]     thread_id,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic                          woken_valid,
  output logic [rlfw_pkg::ID_W-1:0]     woken_thread,
  output logic [rlfw_pkg::ID_W-1:0]     owner_now,
  output logic                          owned_now,
  output logic [rlfw_pkg::DEPTH_W-1:0]  hold_depth,
  output logic [rlfw_pkg::FILL_W-1:0]   queue_length
);
  import rlfw_pkg::*;

  // Input register: holds one transaction while the result register is blocked.
  logic            s1_valid;
  logic            s1_cmd;
  logic [ID_W-1:0] s1_tid;

  // Result register.
  res_t out_res;

  qctrl_t qctrl;
  qstat_t qstat;
  res_t   res;
  logic   adv;

  // The item in the input register is decided, and the lock state updated,
  // in the cycle it moves into the result register.
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_cmd <= cmd;
      s1_tid <= thread_id;
    end
  end

  rlfw_core #(
    .THREADS (THREADS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (adv),
    .cmd   (s1_cmd),
    .tid   (s1_tid),
    .qstat (qstat),
    .qctrl (qctrl),
    .res   (res)
  );

  rlfw_queue #(
    .THREADS (THREADS)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .ctrl (qctrl),
    .stat (qstat)
  );

  // Result valid: set on a new decision, cleared once the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign woken_valid  = out_res.woken_valid;
  assign woken_thread = out_res.woken_thread;
  assign owner_now    = out_res.owner_now;
  assign owned_now    = out_res.owned_now;
  assign hold_depth   = out_res.hold_depth;
  assign queue_length = out_res.queue_length;

`ifndef SYNTHESIS
  // A free lock reports no holder and no depth.
  a_free_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !owned_now) |-> (owner_now == '0 && hold_depth == '0))
    else $error("free lock reports holder or depth");

  // A handoff gives the woken waiter the lock at depth one.
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (out_valid && woken_valid) |->
      (status == ST_HANDOFF && owned_now && owner_now == woken_thread
       && hold_depth == DEPTH_W'(1)))
    else $error("handoff result inconsistent");

  // Queuing a waiter grows the queue by exactly one.
  a_queue_grow: assert property (@(posedge clk) disable iff (rst)
    (adv && res.status == ST_QUEUED) |=> (qstat.fill == $past(qstat.fill) + 1'b1))
    else $error("queue fill did not grow on queued transaction");

  // A decided transaction always lands in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_valid && queue_length == qstat.fill))
    else $error("result register not loaded or queue length mismatch");
`endif

endmodule

@@ tb/tb_recursive_lock_fifo_waiters.sv @@
`timescale 1ns / 1ps

module tb_recursive_lock_fifo_waiters;
  import rlfw_pkg::*;

  localparam int NUM_THREADS  = 16;
  localparam int HOLD_CYCLES  = 300;  // receiver hold-off for the backpressure test
  localparam int STALL_LIMIT  = 5000; // idle cycles tolerated before the watchdog fires
  localparam int RANDOM_ITEMS = 600;

  // Clock, reset and DUT-facing signals; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = 1'b0;
  logic [ID_W-1:0]      thread_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic                 woken_valid;
  logic [ID_W-1:0]      woken_thread;
  logic [ID_W-1:0]      owner_now;
  logic                 owned_now;
  logic [DEPTH_W-1:0]   hold_depth;
  logic [FILL_W-1:0]    queue_length;

  // Lock shadow state, updated at each accepted transaction.
  logic                 lk_held = 1'b0;
  logic [ID_W-1:0]      lk_owner = '0;
  logic [DEPTH_W-1:0]   lk_depth = '0;
  logic [ID_W-1:0]      lk_waiters[$];
  logic [NUM_THREADS-1:0] lk_waiting = '0;

  // Expected lock responses, oldest first.
  res_t                 exp_results[$];
  int                   mismatches = 0;

  // Idle control. quiet is read by the receiver, so it changes with NBAs only;
  // burst is read by the sender process alone.
  logic                 quiet = 1'b0;
  bit                   burst = 1'b0;
  logic                 hold_req = 1'b0;
  logic                 hold_done = 1'b0;
  int                   hold_cnt = 0;
  int                   idle_cycles = 0;

  recursive_lock_fifo_waiters #(
    .THREADS(NUM_THREADS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .thread_id   (thread_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .woken_valid (woken_valid),
    .woken_thread(woken_thread),
    .owner_now   (owner_now),
    .owned_now   (owned_now),
    .hold_depth  (hold_depth),
    .queue_length(queue_length)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lock behavior for one command: updates the shadow state and returns the
  // response the block must produce for it.
  function automatic res_t predict_lock(cmd_t c, logic [ID_W-1:0] tid);
    res_t            r;
    status_t         st;
    logic [ID_W-1:0] nxt;
    r = '0;
    if (int'(tid) >= NUM_THREADS) begin
      st = ST_OTHER_ERR;
    end else if (c == CMD_ACQUIRE) begin
      if (!lk_held) begin
        lk_held  = 1'b1;
        lk_owner = tid;
        lk_depth = DEPTH_W'(1);
        st       = ST_GRANTED;
      end else if (lk_owner == tid) begin
        // saturates at the top depth
        if (lk_depth == MAX_DEPTH) begin
          st = ST_OTHER_ERR;
        end else begin
          lk_depth = lk_depth + 1'b1;
          st       = ST_NESTED;
        end
      end else if (lk_waiting[tid] || lk_waiters.size() >= NUM_THREADS) begin
        st = ST_OTHER_ERR;
      end else begin
        lk_waiters.push_back(tid);
        lk_waiting[tid] = 1'b1;
        st              = ST_QUEUED;
      end
    end else begin
      if (!lk_held || lk_owner != tid) begin
        st = ST_NOT_OWNER;
      end else if (lk_depth > 1) begin
        lk_depth = lk_depth - 1'b1;
        st       = ST_DECREMENT;
      end else if (lk_waiters.size() > 0) begin
        // final release: direct handoff to the head waiter
        nxt             = lk_waiters.pop_front();
        lk_waiting[nxt] = 1'b0;
        lk_owner        = nxt;
        lk_depth        = DEPTH_W'(1);
        st              = ST_HANDOFF;
        r.woken_valid   = 1'b1;
        r.woken_thread  = nxt;
      end else begin
        lk_held  = 1'b0;
        lk_owner = '0;
        lk_depth = '0;
        st       = ST_FREED;
      end
    end
    r.status       = st;
    r.owner_now    = lk_held ? lk_owner : '0;
    r.owned_now    = lk_held;
    r.hold_depth   = lk_held ? lk_depth : '0;
    r.queue_length = FILL_W'(lk_waiters.size());
    return r;
  endfunction

  // Offer one transaction, with a random gap first unless idling is off.
  // in_valid stays high on return so back-to-back transactions need no
  // lower-then-raise in one step.
  task automatic send_item(cmd_t c, logic [ID_W-1:0] tid);
    if (!quiet && !burst) begin
      while ($urandom_range(0, 99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    thread_id <= tid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    exp_results.push_back(predict_lock(c, tid));
  endtask

  // Release by whoever holds the lock until it is free (walks all handoffs).
  task automatic drain_lock();
    while (lk_held) send_item(CMD_RELEASE, lk_owner);
  endtask

  // Basic grant / nest / queue / handoff / free flow plus the error cases:
  // release on a free lock, release by a waiter, double enqueue.
  task automatic test_directed();
    send_item(CMD_RELEASE, 4'd3);   // free lock -> not owner
    send_item(CMD_ACQUIRE, 4'd0);   // granted
    send_item(CMD_ACQUIRE, 4'd0);   // nested
    send_item(CMD_RELEASE, 4'd15);  // not owner
    send_item(CMD_ACQUIRE, 4'd15);  // queued
    send_item(CMD_ACQUIRE, 4'd15);  // already waiting
    send_item(CMD_ACQUIRE, 4'd7);   // queued
    send_item(CMD_RELEASE, 4'd0);   // decrement
    send_item(CMD_RELEASE, 4'd0);   // handoff to 15
    send_item(CMD_RELEASE, 4'd7);   // waiter, not holder
    send_item(CMD_RELEASE, 4'd15);  // handoff to 7
    send_item(CMD_ACQUIRE, 4'd7);   // nested on handed-off lock
    send_item(CMD_RELEASE, 4'd7);
    send_item(CMD_RELEASE, 4'd7);   // freed
    send_item(CMD_ACQUIRE, 4'd15);  // granted to top id
    send_item(CMD_RELEASE, 4'd15);  // freed
  endtask

  // Every other thread waits behind one holder; drained in FIFO order.
  task automatic test_full_queue();
    send_item(CMD_ACQUIRE, 4'd5);
    for (int t = 0; t < NUM_THREADS; t++) send_item(CMD_ACQUIRE, ID_W'(t));
    send_item(CMD_ACQUIRE, 4'd0);   // already waiting
    send_item(CMD_ACQUIRE, 4'd15);  // already waiting
    drain_lock();
  endtask

  // Nest up to the top depth, one more acquire saturates, then unwind.
  task automatic test_depth_saturation();
    send_item(CMD_ACQUIRE, 4'd9);
    for (int n = 1; n < int'(MAX_DEPTH); n++) send_item(CMD_ACQUIRE, 4'd9);
    send_item(CMD_ACQUIRE, 4'd9);   // saturated -> error, depth stays
    send_item(CMD_ACQUIRE, 4'd2);   // waiter for the final handoff
    drain_lock();
  endtask

  // Pick a command that keeps the lock busy: mostly holder releases, nested
  // acquires and new requesters, with some arbitrary noise.
  task automatic send_random(bit fill_mode);
    int               r;
    int               rel_top;
    logic [ID_W-1:0]  tid;
    r       = $urandom_range(0, 99);
    rel_top = fill_mode ? 30 : 70;
    tid     = ID_W'($urandom_range(0, NUM_THREADS - 1));
    if (r < 8)
      send_item(cmd_t'($urandom_range(0, 1)), tid);
    else if (lk_held && r < rel_top)
      send_item(CMD_RELEASE, lk_owner);
    else if (lk_held && r < rel_top + 10)
      send_item(CMD_ACQUIRE, lk_owner);
    else
      send_item(CMD_ACQUIRE, tid);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and in_stall must rise.
  task automatic test_backpressure();
    burst = 1'b1;
    hold_req <= 1'b1;
    for (int n = 0; n < 80; n++) send_random(1'($urandom_range(0, 1)));
    burst = 1'b0;
  endtask

  // Long random run switching at random between fill and drain phases, with one stretch
  // where neither side idles.
  task automatic test_random();
    bit fill_mode;
    fill_mode = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) fill_mode = 1'($urandom_range(0, 1));
      if (n == 200) quiet <= 1'b1;
      if (n == 400) quiet <= 1'b0;
      send_random(fill_mode);
    end
  endtask

  // Output stall: one long hold-off on request, off while quiet, otherwise random.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 22);
    end
  end

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted response against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected response, status %0d owner %0d", $time, status, owner_now);
        mismatches++;
      end else begin
        want = exp_results.pop_front();
        check_field("status",       int'(want.status),       int'(status));
        check_field("woken_valid",  int'(want.woken_valid),  int'(woken_valid));
        check_field("woken_thread", int'(want.woken_thread), int'(woken_thread));
        check_field("owner_now",    int'(want.owner_now),    int'(owner_now));
        check_field("owned_now",    int'(want.owned_now),    int'(owned_now));
        check_field("hold_depth",   int'(want.hold_depth),   int'(hold_depth));
        check_field("queue_length", int'(want.queue_length), int'(queue_length));
      end
    end
  end

  // Watchdog: too many cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_depth_saturation();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    // drain outstanding responses; the watchdog covers a hang
    while (exp_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
